/* rtl/core/tccw_pkg.sv */
// Shared types and constants for the text console character writer.
// Holds field widths, operation, register and character codes, reset sizes and controller/datapath structs.
// No dependencies.
package tccw_pkg;

    localparam int OP_W       = 2;
    localparam int CHAR_W     = 8;
    localparam int RD_ROW_W   = 6;
    localparam int RD_COL_W   = 7;
    localparam int CUR_COL_W  = 7;
    localparam int CUR_ROW_W  = 6;
    localparam int BOX_LEFT_W = 7;
    localparam int BOX_TOP_W  = 6;
    localparam int BOX_RGT_W  = 8;
    localparam int BOX_BOT_W  = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int ROWS_CFG_W = 7;

    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd1;

    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

    localparam int RST_ROW_COUNT = 24;
    localparam int RST_COL_COUNT = 80;

    typedef struct packed {
        logic clear_step;
        logic exec;
        logic sweep_step;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic need_scroll;
        logic sweep_last;
    } dp_status_t;

endpackage

/* rtl/core/tccw_ctrl.sv */
// Controller state machine for the text console character writer.
// Sequences the reset clear pass, item execution, row sweep and result hand-off.
// Depends on tccw_pkg.
module tccw_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   out_stall,
    input  tccw_pkg::dp_status_t   status,
    output tccw_pkg::ctrl_cmd_t    cmd,
    output logic                   in_stall,
    output logic                   out_valid
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SWEEP,
        ST_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.exec   = 1'b1;
                    state_next = status.need_scroll ? ST_SWEEP : ST_RESULT;
                end
            end
            ST_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

/* rtl/core/tccw_datapath.sv */
// Datapath for the text console character writer: cell memory, cursor,
// dirty box, row ring offset, size registers and result register.
// Depends on tccw_pkg; driven by tccw_ctrl commands.
module tccw_datapath #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 128
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [tccw_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tccw_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [tccw_pkg::OP_W-1:0]            operation,
    input  logic [tccw_pkg::CHAR_W-1:0]          char_code,
    input  logic [tccw_pkg::RD_ROW_W-1:0]        read_row,
    input  logic [tccw_pkg::RD_COL_W-1:0]        read_col,
    input  tccw_pkg::ctrl_cmd_t                  cmd,
    output tccw_pkg::dp_status_t                 status,
    output logic [tccw_pkg::CHAR_W-1:0]          read_char,
    output logic [tccw_pkg::CUR_COL_W-1:0]       cursor_col,
    output logic [tccw_pkg::CUR_ROW_W-1:0]       cursor_row,
    output logic [tccw_pkg::BOX_LEFT_W-1:0]      dirty_left,
    output logic [tccw_pkg::BOX_TOP_W-1:0]       dirty_top,
    output logic [tccw_pkg::BOX_RGT_W-1:0]       dirty_right,
    output logic [tccw_pkg::BOX_BOT_W-1:0]       dirty_bottom,
    output logic                                 scrolled
);

    localparam int RW       = $clog2(MAX_ROWS);
    localparam int CW       = $clog2(MAX_COLS);
    localparam int RCW      = $clog2(MAX_ROWS + 1);
    localparam int CCW      = $clog2(MAX_COLS + 1);
    localparam int AW       = RW + CW;
    localparam int DEPTH    = MAX_ROWS * (2 ** CW);
    localparam int RST_ROWS = (tccw_pkg::RST_ROW_COUNT > MAX_ROWS) ? MAX_ROWS
                                                                  : tccw_pkg::RST_ROW_COUNT;
    localparam int RST_COLS = (tccw_pkg::RST_COL_COUNT > MAX_COLS) ? MAX_COLS
                                                                  : tccw_pkg::RST_COL_COUNT;

    logic [tccw_pkg::CHAR_W-1:0] mem [0:DEPTH-1];

    logic [RCW-1:0] row_cnt_reg;
    logic [CCW-1:0] col_cnt_reg;
    logic [CW-1:0]  cur_x_reg;
    logic [RW-1:0]  cur_y_reg;
    logic [RW-1:0]  offset_reg;
    logic [CW-1:0]  box_left_reg;
    logic [RW-1:0]  box_top_reg;
    logic [CCW-1:0] box_right_reg;
    logic [RCW-1:0] box_bottom_reg;
    logic [AW-1:0]  sweep_cnt_reg;
    logic           scrolled_reg;
    logic           rd_op_reg;
    logic           rd_ok_reg;
    logic [tccw_pkg::CHAR_W-1:0] rdata_reg;

    logic [tccw_pkg::CHAR_W-1:0]     out_char_reg;
    logic [tccw_pkg::CUR_COL_W-1:0]  out_col_reg;
    logic [tccw_pkg::CUR_ROW_W-1:0]  out_row_reg;
    logic [tccw_pkg::BOX_LEFT_W-1:0] out_left_reg;
    logic [tccw_pkg::BOX_TOP_W-1:0]  out_top_reg;
    logic [tccw_pkg::BOX_RGT_W-1:0]  out_right_reg;
    logic [tccw_pkg::BOX_BOT_W-1:0]  out_bottom_reg;
    logic                            out_scrolled_reg;

    logic [tccw_pkg::ROWS_CFG_W-1:0] cfg_rows_raw;
    logic [RCW-1:0] rows_clamp;
    logic [CCW-1:0] cols_clamp;

    logic           is_put;
    logic           is_cr;
    logic           is_lf;
    logic           is_store;
    logic [CCW-1:0] x_inc;
    logic [RCW-1:0] y_inc;
    logic [RCW-1:0] off_inc;
    logic           wrap;
    logic           lf;
    logic           need_scroll;
    logic           rd_ok;
    logic [RW-1:0]  cur_phys;
    logic [RW-1:0]  rd_phys;
    logic           clear_last;
    logic           sweep_last;

    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [tccw_pkg::CHAR_W-1:0] mem_wdata;
    logic                        mem_re;
    logic [AW-1:0]               mem_raddr;

    function automatic logic [RW-1:0] phys_row(input logic [RW-1:0]  r,
                                               input logic [RW-1:0]  off,
                                               input logic [RCW-1:0] cnt);
        logic [RW:0] p;
        p = {1'b0, r} + {1'b0, off};
        if (p >= (RW+1)'(cnt))
        begin
            p = p - (RW+1)'(cnt);
        end
        return p[RW-1:0];
    endfunction

    assign cfg_rows_raw = cfg_data[tccw_pkg::ROWS_CFG_W-1:0];

    always_comb
    begin
        if (cfg_rows_raw == '0)
        begin
            rows_clamp = RCW'(1);
        end
        else if (32'(cfg_rows_raw) > MAX_ROWS)
        begin
            rows_clamp = RCW'(MAX_ROWS);
        end
        else
        begin
            rows_clamp = RCW'(cfg_rows_raw);
        end
        if (cfg_data == '0)
        begin
            cols_clamp = CCW'(1);
        end
        else if (32'(cfg_data) > MAX_COLS)
        begin
            cols_clamp = CCW'(MAX_COLS);
        end
        else
        begin
            cols_clamp = CCW'(cfg_data);
        end
    end

    assign is_put      = (operation == tccw_pkg::OP_PUT);
    assign is_cr       = (char_code == tccw_pkg::CH_CR);
    assign is_lf       = (char_code == tccw_pkg::CH_LF);
    assign is_store    = is_put && !is_cr && !is_lf;
    assign x_inc       = CCW'(cur_x_reg) + CCW'(1);
    assign y_inc       = RCW'(cur_y_reg) + RCW'(1);
    assign off_inc     = RCW'(offset_reg) + RCW'(1);
    assign wrap        = is_store && (x_inc >= col_cnt_reg);
    assign lf          = (is_put && is_lf) || wrap;
    assign need_scroll = lf && (y_inc >= row_cnt_reg);
    assign rd_ok       = (32'(read_row) < 32'(row_cnt_reg)) &&
                         (32'(read_col) < 32'(col_cnt_reg));
    assign cur_phys    = phys_row(cur_y_reg, offset_reg, row_cnt_reg);
    assign rd_phys     = phys_row(RW'(read_row), offset_reg, row_cnt_reg);
    assign clear_last  = (sweep_cnt_reg == AW'(DEPTH - 1));
    assign sweep_last  = (sweep_cnt_reg[CW-1:0] == CW'(MAX_COLS - 1));

    assign status.clear_last  = clear_last;
    assign status.need_scroll = need_scroll;
    assign status.sweep_last  = sweep_last;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = sweep_cnt_reg;
        mem_wdata = tccw_pkg::CH_SPACE;
        if (cmd.clear_step)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.sweep_step)
        begin
            mem_we    = 1'b1;
            mem_waddr = {offset_reg, sweep_cnt_reg[CW-1:0]};
        end
        else if (cmd.exec && is_store)
        begin
            mem_we    = 1'b1;
            mem_waddr = {cur_phys, cur_x_reg};
            mem_wdata = char_code;
        end
    end

    assign mem_re    = cmd.exec && (operation == tccw_pkg::OP_READ);
    assign mem_raddr = {rd_phys, CW'(read_col)};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg    <= RCW'(RST_ROWS);
            col_cnt_reg    <= CCW'(RST_COLS);
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            offset_reg     <= '0;
            box_left_reg   <= '0;
            box_top_reg    <= '0;
            box_right_reg  <= '0;
            box_bottom_reg <= '0;
            sweep_cnt_reg  <= '0;
            scrolled_reg   <= 1'b0;
            rd_op_reg      <= 1'b0;
            rd_ok_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == tccw_pkg::REG_ROW_COUNT ||
                           cfg_index == tccw_pkg::REG_COL_COUNT))
            begin
                if (cfg_index == tccw_pkg::REG_ROW_COUNT)
                begin
                    row_cnt_reg <= rows_clamp;
                end
                else
                begin
                    col_cnt_reg <= cols_clamp;
                end
                cur_x_reg  <= '0;
                cur_y_reg  <= '0;
                offset_reg <= '0;
            end
            if (cmd.clear_step)
            begin
                sweep_cnt_reg <= clear_last ? '0 : sweep_cnt_reg + AW'(1);
            end
            if (cmd.exec)
            begin
                sweep_cnt_reg <= '0;
                scrolled_reg  <= need_scroll;
                rd_op_reg     <= (operation == tccw_pkg::OP_READ);
                rd_ok_reg     <= rd_ok;
                case (operation)
                    tccw_pkg::OP_PUT:
                    begin
                        if (is_store)
                        begin
                            if (box_right_reg == '0)
                            begin
                                box_left_reg   <= cur_x_reg;
                                box_right_reg  <= x_inc;
                                box_top_reg    <= cur_y_reg;
                                box_bottom_reg <= y_inc;
                            end
                            else
                            begin
                                if (cur_x_reg < box_left_reg)
                                begin
                                    box_left_reg <= cur_x_reg;
                                end
                                if (cur_y_reg < box_top_reg)
                                begin
                                    box_top_reg <= cur_y_reg;
                                end
                                if (x_inc > box_right_reg)
                                begin
                                    box_right_reg <= x_inc;
                                end
                                if (y_inc > box_bottom_reg)
                                begin
                                    box_bottom_reg <= y_inc;
                                end
                            end
                        end
                        if (lf)
                        begin
                            cur_x_reg <= '0;
                            if (!need_scroll)
                            begin
                                cur_y_reg <= RW'(y_inc);
                            end
                        end
                        else if (is_cr)
                        begin
                            cur_x_reg <= '0;
                        end
                        else
                        begin
                            cur_x_reg <= CW'(x_inc);
                        end
                    end
                    tccw_pkg::OP_CLEAR:
                    begin
                        box_left_reg   <= '0;
                        box_top_reg    <= '0;
                        box_right_reg  <= '0;
                        box_bottom_reg <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.sweep_step)
            begin
                sweep_cnt_reg <= sweep_cnt_reg + AW'(1);
                if (sweep_last)
                begin
                    offset_reg <= (off_inc >= row_cnt_reg) ? '0 : RW'(off_inc);
                    if (box_top_reg != '0)
                    begin
                        box_top_reg <= box_top_reg - RW'(1);
                    end
                    if (box_bottom_reg != '0)
                    begin
                        box_bottom_reg <= box_bottom_reg - RCW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_char_reg     <= (rd_op_reg && rd_ok_reg) ? rdata_reg : '0;
            out_col_reg      <= tccw_pkg::CUR_COL_W'(cur_x_reg);
            out_row_reg      <= tccw_pkg::CUR_ROW_W'(cur_y_reg);
            out_left_reg     <= tccw_pkg::BOX_LEFT_W'(box_left_reg);
            out_top_reg      <= tccw_pkg::BOX_TOP_W'(box_top_reg);
            out_right_reg    <= tccw_pkg::BOX_RGT_W'(box_right_reg);
            out_bottom_reg   <= tccw_pkg::BOX_BOT_W'(box_bottom_reg);
            out_scrolled_reg <= scrolled_reg;
        end
    end

    assign read_char    = out_char_reg;
    assign cursor_col   = out_col_reg;
    assign cursor_row   = out_row_reg;
    assign dirty_left   = out_left_reg;
    assign dirty_top    = out_top_reg;
    assign dirty_right  = out_right_reg;
    assign dirty_bottom = out_bottom_reg;
    assign scrolled     = out_scrolled_reg;

endmodule

/* rtl/core/text_console_char_writer_top.sv */
// Top level of the text console character writer.
// Instantiates tccw_ctrl and tccw_datapath; depends on tccw_pkg.
//
//   channel | handshake            | payload
//   --------+----------------------+--------------------------------------------
//   in      | in_valid / in_stall  | operation, char_code, read_row, read_col
//   out     | out_valid/ out_stall | read_char, cursor_col, cursor_row, dirty_*,
//           |                      | scrolled
//   cfg     | cfg_valid/ cfg_ready | cfg_index, cfg_data
//
// Each item executes against the cell memory and is then loaded into the result
// register. A put that scrolls first sweeps the recycled row to spaces.
// After reset all MAX_ROWS * 2**clog2(MAX_COLS) cells (8192 at defaults) are
// swept to spaces, one cell a cycle; in_stall stays high meanwhile.
// A result waits in the output register while out_stall is high; the next item
// is accepted and executed meanwhile and held until the register frees.
module text_console_char_writer_top #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 128
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [tccw_pkg::OP_W-1:0]            operation,
    input  logic [tccw_pkg::CHAR_W-1:0]          char_code,
    input  logic [tccw_pkg::RD_ROW_W-1:0]        read_row,
    input  logic [tccw_pkg::RD_COL_W-1:0]        read_col,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [tccw_pkg::CHAR_W-1:0]          read_char,
    output logic [tccw_pkg::CUR_COL_W-1:0]       cursor_col,
    output logic [tccw_pkg::CUR_ROW_W-1:0]       cursor_row,
    output logic [tccw_pkg::BOX_LEFT_W-1:0]      dirty_left,
    output logic [tccw_pkg::BOX_TOP_W-1:0]       dirty_top,
    output logic [tccw_pkg::BOX_RGT_W-1:0]       dirty_right,
    output logic [tccw_pkg::BOX_BOT_W-1:0]       dirty_bottom,
    output logic                                 scrolled,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tccw_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tccw_pkg::CFG_DATA_W-1:0]      cfg_data
);

    tccw_pkg::ctrl_cmd_t  cmd;
    tccw_pkg::dp_status_t status;
    logic                 cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    tccw_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid)
    );

    tccw_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .operation    (operation),
        .char_code    (char_code),
        .read_row     (read_row),
        .read_col     (read_col),
        .cmd          (cmd),
        .status       (status),
        .read_char    (read_char),
        .cursor_col   (cursor_col),
        .cursor_row   (cursor_row),
        .dirty_left   (dirty_left),
        .dirty_top    (dirty_top),
        .dirty_right  (dirty_right),
        .dirty_bottom (dirty_bottom),
        .scrolled     (scrolled)
    );

endmodule

/* rtl/core/tccw_checker.sv */
// Port-level checker for text_console_char_writer_top, with its bind.
// Depends on tccw_pkg widths only.
module tccw_checker
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_stall,
    input  logic                                 out_valid,
    input  logic                                 out_stall,
    input  logic [tccw_pkg::CHAR_W-1:0]          read_char,
    input  logic [tccw_pkg::CUR_COL_W-1:0]       cursor_col,
    input  logic [tccw_pkg::BOX_LEFT_W-1:0]      dirty_left,
    input  logic [tccw_pkg::BOX_TOP_W-1:0]       dirty_top,
    input  logic [tccw_pkg::BOX_RGT_W-1:0]       dirty_right,
    input  logic [tccw_pkg::BOX_BOT_W-1:0]       dirty_bottom,
    input  logic                                 scrolled
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_char) && $stable(cursor_col))
        else $error("stalled result transaction dropped or changed");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second input transaction taken while one is in flight");

    a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dirty_right != '0 |->
            (8'(dirty_left) < dirty_right) && (7'(dirty_top) <= dirty_bottom))
        else $error("dirty box bounds out of order");

    a_scroll_put: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && scrolled |-> cursor_col == '0 && read_char == '0)
        else $error("scroll result with cursor off column 0 or nonzero read data");

endmodule

bind text_console_char_writer_top tccw_checker u_tccw_checker (.*);
